/* hw/rtl/xcfp_pkg.sv */
package xcfp_pkg;

  localparam int unsigned MaxDataBytesDef = 32;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DlenW  = 6;
  localparam int unsigned BidxW  = 5;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'hAA;

endpackage

/* hw/rtl/xcfp_store.sv */
module xcfp_store import xcfp_pkg::*; #(
  parameter int unsigned Depth = MaxDataBytesDef,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [ByteW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/xor_checked_frame_parser.sv */
// Frame parser: takes one received byte per item and hunts for frames of the form start marker,
// length, command, data bytes, XOR checksum (over length, command and data). Bytes are taken
// without a stall while a frame is received, but the checksum byte waits for a free output
// register; data bytes are buffered in a small memory. After a good checksum the buffered
// data is replayed from that memory, each result by a memory read and then a load of the
// output register once it is free, during which no byte is taken; a command-only frame gives
// its one result with the checksum byte. Bad lengths and bad checksums drop the frame without
// results. The start marker register may be written at any idle moment and resets to 0xAA.
module xor_checked_frame_parser import xcfp_pkg::*; #(
  parameter int unsigned MaxDataBytes = MaxDataBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] frame_command_o,
  output logic [DlenW-1:0] data_length_o,
  output logic [BidxW-1:0] byte_index_o,
  output logic [ByteW-1:0] data_byte_o,
  output logic             has_data_o,
  output logic             last_item_o
);

  localparam int unsigned LenW  = $clog2(MaxDataBytes + 2);
  localparam int unsigned CntW  = $clog2(MaxDataBytes + 1);
  localparam int unsigned AddrW = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;

  typedef enum logic [2:0] {
    HuntSt,
    LenSt,
    CmdSt,
    DataSt,
    ChkSt,
    EmitRdSt,
    EmitWrSt
  } state_e;

  state_e            state_q;
  logic [ByteW-1:0]  marker_q;
  logic [LenW-1:0]   len_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   k_q;
  logic [ByteW-1:0]  csum_q;
  logic [ByteW-1:0]  cmd_q;

  logic              out_valid_q;
  logic [ByteW-1:0]  out_cmd_q;
  logic [DlenW-1:0]  out_dlen_q;
  logic [BidxW-1:0]  out_idx_q;
  logic [ByteW-1:0]  out_data_q;
  logic              out_has_q;
  logic              out_last_q;

  logic              in_fire;
  logic              out_free;
  logic [LenW-1:0]   dl;
  logic              len_bad;
  logic              data_done;
  logic              emit_last;
  logic              wr_en;
  logic [ByteW-1:0]  rd_data;
  logic              chk_ok;
  logic              out_load;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign dl        = len_q - LenW'(1);
  assign len_bad   = (rx_byte_i == '0) || (rx_byte_i > ByteW'(MaxDataBytes + 1));
  assign data_done = ((LenW + 1)'(cnt_q) + (LenW + 1)'(2)) >= (LenW + 1)'(len_q);
  assign emit_last = (LenW'(k_q) + LenW'(1)) == dl;
  assign wr_en     = in_fire && (state_q == DataSt) && (cnt_q < CntW'(MaxDataBytes));
  assign chk_ok    = (rx_byte_i == csum_q);
  assign out_load  = ((state_q == ChkSt) && in_fire && chk_ok && (dl == '0)) ||
                     ((state_q == EmitWrSt) && out_free);

  always_comb begin
    unique case (state_q)
      HuntSt, LenSt, CmdSt, DataSt: in_ready_o = 1'b1;
      ChkSt:                        in_ready_o = out_free;
      default:                      in_ready_o = 1'b0;
    endcase
  end

  xcfp_store #(
    .Depth (MaxDataBytes),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (state_q == EmitRdSt),
    .rd_addr_i (k_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= HuntSt;
      marker_q    <= StartMarkerRst;
      len_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      csum_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
      out_cmd_q   <= '0;
      out_dlen_q  <= '0;
      out_idx_q   <= '0;
      out_data_q  <= '0;
      out_has_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        HuntSt: begin
          if (in_fire && (rx_byte_i == marker_q)) begin
            state_q <= LenSt;
            cnt_q   <= '0;
            csum_q  <= '0;
          end
        end
        LenSt: begin
          if (in_fire) begin
            cnt_q <= '0;
            if (len_bad) begin
              state_q <= HuntSt;
              len_q   <= '0;
              csum_q  <= '0;
            end else begin
              state_q <= CmdSt;
              len_q   <= rx_byte_i[LenW-1:0];
              csum_q  <= rx_byte_i;
            end
          end
        end
        CmdSt: begin
          if (in_fire) begin
            cmd_q   <= rx_byte_i;
            csum_q  <= csum_q ^ rx_byte_i;
            state_q <= (len_q == LenW'(1)) ? ChkSt : DataSt;
          end
        end
        DataSt: begin
          if (in_fire) begin
            csum_q <= csum_q ^ rx_byte_i;
            cnt_q  <= cnt_q + CntW'(1);
            if (data_done) begin
              state_q <= ChkSt;
            end
          end
        end
        ChkSt: begin
          if (in_fire) begin
            cnt_q  <= '0;
            csum_q <= '0;
            if (chk_ok && (dl != '0)) begin
              k_q     <= '0;
              state_q <= EmitRdSt;
            end else begin
              state_q <= HuntSt;
            end
            if (chk_ok && (dl == '0)) begin
              // command-only frame: one result, no data
              out_cmd_q   <= cmd_q;
              out_dlen_q  <= '0;
              out_idx_q   <= '0;
              out_data_q  <= '0;
              out_has_q   <= 1'b0;
              out_last_q  <= 1'b1;
            end
          end
        end
        EmitRdSt: begin
          state_q <= EmitWrSt;
        end
        EmitWrSt: begin
          if (out_free) begin
            out_cmd_q   <= cmd_q;
            out_dlen_q  <= DlenW'(dl);
            out_idx_q   <= BidxW'(k_q);
            out_data_q  <= rd_data;
            out_has_q   <= 1'b1;
            out_last_q  <= emit_last;
            k_q         <= k_q + CntW'(1);
            state_q     <= emit_last ? HuntSt : EmitRdSt;
          end
        end
        default: begin
          state_q <= HuntSt;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_command_o = out_cmd_q;
  assign data_length_o   = out_dlen_q;
  assign byte_index_o    = out_idx_q;
  assign data_byte_o     = out_data_q;
  assign has_data_o      = out_has_q;
  assign last_item_o     = out_last_q;

  // a bad checksum never starts a replay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ChkSt) && in_fire && (rx_byte_i != csum_q) |=> (state_q == HuntSt))
    else $error("replay started after bad checksum");

  // frame length and command hold for the whole replay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmitRdSt) |=> $stable(len_q) && $stable(cmd_q))
    else $error("frame registers changed during replay");

  // a result without data is the only result of its frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_item_o && (data_length_o == '0))
    else $error("command-only result malformed");

  // a new result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmitWrSt) && out_valid_q && !out_ready_i |=> $stable(out_idx_q))
    else $error("pending result overwritten");

endmodule
